>>> rtl/core/dh_forward_kinematics_5dof_assert.svh
// Assertion macros for the five-joint forward kinematics block.
// Used by dh_forward_kinematics_5dof; expects a clk and rst in scope.
`ifndef DH_FORWARD_KINEMATICS_5DOF_ASSERT_SVH
`define DH_FORWARD_KINEMATICS_5DOF_ASSERT_SVH

// same-cycle implication
`define DHFK_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define DHFK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/core/dhfk_pkg.sv
// Shared types, constants and helpers for the forward kinematics pipeline.
// No dependencies.
`timescale 1ns / 1ps
package dhfk_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_DEPTH = 24;

  localparam logic [2:0] REG_BASE_HEIGHT = 3'd0;
  localparam logic [2:0] REG_LINK_LEN_0  = 3'd1;
  localparam logic [2:0] REG_LINK_LEN_1  = 3'd2;
  localparam logic [2:0] REG_LINK_LEN_2  = 3'd3;
  localparam logic [2:0] REG_LINK_LEN_3  = 3'd4;
  localparam logic [2:0] REG_LINK_LEN_4  = 3'd5;
  localparam logic [2:0] REG_LINK_LEN_5  = 3'd6;

  localparam logic signed [31:0] Q30_ONE   = 32'sh4000_0000;
  localparam logic signed [31:0] CORDIC_K  = 32'sd652032874;
  localparam logic signed [17:0] DEG90     = 18'sd11520;

  // arctan(2^-i), 2^-20 degree
  localparam logic signed [31:0] ATAN_TAB [ATAN_DEPTH] = '{
    32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
    32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
    32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
    32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
    32'sd917,      32'sd458,      32'sd229,      32'sd115,
    32'sd57,       32'sd29,       32'sd14,       32'sd7
  };

  typedef logic signed [31:0] q30_t;

  typedef struct packed {
    logic [2:0][2:0][31:0] rm;
    logic [2:0][49:0]      p;
  } frame_t;

  function automatic q30_t rnd_clamp(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v + 64'sd536870912) >>> 30;
    if (t > 64'sd1073741824) begin
      return Q30_ONE;
    end else if (t < -64'sd1073741824) begin
      return -Q30_ONE;
    end
    return t[31:0];
  endfunction

endpackage

>>> rtl/core/dhfk_cordic.sv
// Pipelined rotation-mode CORDIC: link angle (1/128 deg) to Q30 cos/sin.
// Depends on dhfk_pkg; optional output delay line for later links.
`timescale 1ns / 1ps
module dhfk_cordic import dhfk_pkg::*; #(
  parameter int STAGES    = CORDIC_STAGES_DEF,
  parameter int OUT_DELAY = 0
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [17:0] angle,
  output q30_t               cos_o,
  output q30_t               sin_o
);
  localparam int NS = (STAGES > ATAN_DEPTH) ? ATAN_DEPTH : STAGES;

  logic signed [18:0] wrap_sum;
  logic signed [18:0] wrapped;
  logic signed [15:0] ang;
  logic signed [15:0] ang_f;
  logic               fold;

  logic signed [33:0] xs [0:NS];
  logic signed [33:0] ys [0:NS];
  logic signed [31:0] zs [0:NS];
  logic               negs [0:NS];

  logic signed [33:0] xn;
  logic signed [33:0] yn;
  q30_t cd [0:OUT_DELAY];
  q30_t sd [0:OUT_DELAY];

  always_comb begin
    wrap_sum = {angle[17], angle} + 19'sd69120;
    if (wrap_sum >= 19'sd92160) begin
      wrapped = wrap_sum - 19'sd92160;
    end else if (wrap_sum >= 19'sd46080) begin
      wrapped = wrap_sum - 19'sd46080;
    end else begin
      wrapped = wrap_sum;
    end
    ang = 16'(wrapped - 19'sd23040);
    fold = 1'b0;
    ang_f = ang;
    if (ang > 16'sd11520) begin
      ang_f = ang - 16'sd23040;
      fold = 1'b1;
    end else if (ang < -16'sd11520) begin
      ang_f = ang + 16'sd23040;
      fold = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]   <= 34'(CORDIC_K);
      ys[0]   <= '0;
      zs[0]   <= 32'(ang_f) <<< 13;
      negs[0] <= fold;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        negs[i+1] <= negs[i];
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN_TAB[i];
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN_TAB[i];
        end
      end
    end
  end

  always_comb begin
    xn = negs[NS] ? -xs[NS] : xs[NS];
    yn = negs[NS] ? -ys[NS] : ys[NS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cd[0] <= (xn > 34'sd1073741824) ? Q30_ONE :
               (xn < -34'sd1073741824) ? -Q30_ONE : xn[31:0];
      sd[0] <= (yn > 34'sd1073741824) ? Q30_ONE :
               (yn < -34'sd1073741824) ? -Q30_ONE : yn[31:0];
    end
  end

  for (genvar k = 0; k < OUT_DELAY; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        cd[k+1] <= cd[k];
        sd[k+1] <= sd[k];
      end
    end
  end

  assign cos_o = cd[OUT_DELAY];
  assign sin_o = sd[OUT_DELAY];
endmodule

>>> rtl/core/dhfk_link.sv
// One Denavit-Hartenberg link applied to a running frame, three stages:
// products, round/clamp, position update. Depends on dhfk_pkg.
`timescale 1ns / 1ps
module dhfk_link import dhfk_pkg::*; #(
  parameter bit TWIST90 = 1'b0
) (
  input  logic        clk,
  input  logic        en,
  input  frame_t      fin,
  input  q30_t        c,
  input  q30_t        s,
  input  logic [14:0] a,
  input  logic [14:0] d,
  output frame_t      fout
);
  logic signed [63:0] cp0 [3];
  logic signed [63:0] sp1 [3];
  logic signed [63:0] cp1 [3];
  logic signed [63:0] sp0 [3];
  logic signed [46:0] dp1 [3];
  logic signed [46:0] dp2 [3];
  frame_t f1;
  frame_t f2;

  always_ff @(posedge clk) begin
    if (en) begin
      f1 <= fin;
      for (int r = 0; r < 3; r++) begin
        cp0[r] <= c * $signed(fin.rm[r][0]);
        sp1[r] <= s * $signed(fin.rm[r][1]);
        cp1[r] <= c * $signed(fin.rm[r][1]);
        sp0[r] <= s * $signed(fin.rm[r][0]);
        dp1[r] <= $signed({1'b0, d}) * $signed(fin.rm[r][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2.p <= f1.p;
      for (int r = 0; r < 3; r++) begin
        dp2[r] <= dp1[r];
        f2.rm[r][0] <= rnd_clamp(cp0[r] + sp1[r]);
        if (TWIST90) begin
          f2.rm[r][1] <= f1.rm[r][2];
          f2.rm[r][2] <= rnd_clamp(sp0[r] - cp1[r]);
        end else begin
          f2.rm[r][1] <= rnd_clamp(cp1[r] - sp0[r]);
          f2.rm[r][2] <= f1.rm[r][2];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fout.rm <= f2.rm;
      for (int r = 0; r < 3; r++) begin
        fout.p[r] <= $signed(f2.p[r]) + 50'(dp2[r])
                   + 50'($signed({1'b0, a}) * $signed(f2.rm[r][0]));
      end
    end
  end
endmodule

>>> rtl/core/dh_forward_kinematics_5dof.sv
// Five-joint forward kinematics: joint angles to base-to-tool transform.
// Up to 24 CORDIC stages; one beat per cycle while the output is not stalled.
// Depth set by the CORDIC stage chain plus three stages per link in series.
// A stall while out_valid is high freezes the whole pipeline; input stall follows it.
// rst (sync, high) clears valid bits and loads register defaults.
`timescale 1ns / 1ps
module dh_forward_kinematics_5dof import dhfk_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [13:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] joint1_angle,
  input  logic signed [15:0] joint2_angle,
  input  logic signed [15:0] joint3_angle,
  input  logic signed [15:0] joint4_angle,
  input  logic signed [15:0] joint5_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] rot_00,
  output logic signed [15:0] rot_01,
  output logic signed [15:0] rot_02,
  output logic signed [15:0] rot_10,
  output logic signed [15:0] rot_11,
  output logic signed [15:0] rot_12,
  output logic signed [15:0] rot_20,
  output logic signed [15:0] rot_21,
  output logic signed [15:0] rot_22,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] pos_z
);
  `include "dh_forward_kinematics_5dof_assert.svh"

  localparam int NS  = (CORDIC_STAGES > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STAGES;
  localparam int LAT = NS + 18;

  logic [13:0] base_height, link_len_0, link_len_1, link_len_2;
  logic [13:0] link_len_3, link_len_4, link_len_5;
  logic        en;
  logic [LAT-1:0] vld;

  logic signed [17:0] th [5];
  q30_t   cs [5];
  q30_t   sn [5];
  frame_t fr [0:5];
  logic [14:0] la [5];
  logic [14:0] ld [5];
  logic signed [16:0] rr [9];
  logic signed [19:0] pr [3];
  logic signed [15:0] ps [3];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      base_height <= 14'd2432;
      link_len_0  <= 14'd512;
      link_len_1  <= 14'd2637;
      link_len_2  <= 14'd2458;
      link_len_3  <= 14'd1024;
      link_len_4  <= 14'd640;
      link_len_5  <= 14'd1280;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_HEIGHT: base_height <= cfg_data;
        REG_LINK_LEN_0:  link_len_0  <= cfg_data;
        REG_LINK_LEN_1:  link_len_1  <= cfg_data;
        REG_LINK_LEN_2:  link_len_2  <= cfg_data;
        REG_LINK_LEN_3:  link_len_3  <= cfg_data;
        REG_LINK_LEN_4:  link_len_4  <= cfg_data;
        REG_LINK_LEN_5:  link_len_5  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_comb begin
    th[0] = 18'(joint1_angle);
    th[1] = 18'(joint2_angle) + DEG90;
    th[2] = -18'(joint3_angle);
    th[3] = DEG90 - 18'(joint4_angle);
    th[4] = 18'(joint5_angle);
    la[0] = '0;                  ld[0] = {1'b0, link_len_0};
    la[1] = {1'b0, link_len_1};  ld[1] = '0;
    la[2] = {1'b0, link_len_2};  ld[2] = '0;
    la[3] = {1'b0, link_len_4};  ld[3] = '0;
    la[4] = '0;                  ld[4] = {1'b0, link_len_3} + {1'b0, link_len_5};
    fr[0].rm = '0;
    fr[0].rm[0][0] = Q30_ONE;
    fr[0].rm[1][1] = Q30_ONE;
    fr[0].rm[2][2] = Q30_ONE;
    fr[0].p = '0;
    fr[0].p[2] = 50'({base_height, 30'b0});
  end

  for (genvar k = 0; k < 5; k++) begin : g_link
    dhfk_cordic #(.STAGES(NS), .OUT_DELAY(3 * k)) u_cordic (
      .clk(clk), .en(en), .angle(th[k]), .cos_o(cs[k]), .sin_o(sn[k])
    );
    dhfk_link #(.TWIST90((k == 0) || (k == 3))) u_link (
      .clk(clk), .en(en), .fin(fr[k]), .c(cs[k]), .s(sn[k]),
      .a(la[k]), .d(ld[k]), .fout(fr[k+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      rr[i] = 17'(($signed(fr[5].rm[i/3][i%3]) + 32'sd32768) >>> 16);
    end
    for (int r = 0; r < 3; r++) begin
      pr[r] = 20'(($signed(fr[5].p[r]) + 50'sd536870912) >>> 30);
      if (pr[r] > 20'sd32767) begin
        ps[r] = 16'sh7fff;
      end else if (pr[r] < -20'sd32768) begin
        ps[r] = 16'sh8000;
      end else begin
        ps[r] = pr[r][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_00 <= rr[0][15:0];
      rot_01 <= rr[1][15:0];
      rot_02 <= rr[2][15:0];
      rot_10 <= rr[3][15:0];
      rot_11 <= rr[4][15:0];
      rot_12 <= rr[5][15:0];
      rot_20 <= rr[6][15:0];
      rot_21 <= rr[7][15:0];
      rot_22 <= rr[8][15:0];
      pos_x  <= ps[0];
      pos_y  <= ps[1];
      pos_z  <= ps[2];
    end
  end

  `DHFK_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid)
  `DHFK_ASSERT_IMPL(a_rot00_range, out_valid, rot_00 >= -16'sd16384 && rot_00 <= 16'sd16384)
  `DHFK_ASSERT_IMPL(a_rot22_range, out_valid, rot_22 >= -16'sd16384 && rot_22 <= 16'sd16384)
endmodule

>>> tb/dh_forward_kinematics_5dof_tb.sv
// Self-checking bench for the five-joint forward kinematics pipeline.
// Depends on dhfk_pkg and dh_forward_kinematics_5dof; transform predicted in-bench.
// Directed table first, then random joint sets across several link settings.
`timescale 1ns / 1ps
module dh_forward_kinematics_5dof_tb;
  import dhfk_pkg::*;

  localparam int LATENCY   = CORDIC_STAGES_DEF + 18;
  localparam int WDOG_MAX  = 4000;
  localparam int N_RANDOM  = 850;
  localparam int NUM_REGS  = 7;
  localparam longint ONE30 = 64'sd1 << 30;
  localparam int D90  = 11520;
  localparam int D180 = 23040;
  localparam int D360 = 46080;

  typedef struct {
    logic signed [15:0] f [12];
  } pose_t;

  typedef struct {
    logic signed [15:0] j [5];
    bit                 known;
    pose_t              pose;
  } vec_row_t;

  logic clk, rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [13:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [15:0] j1, j2, j3, j4, j5;
  logic signed [15:0] o [12];

  int unsigned link_reg [NUM_REGS];
  pose_t pose_q [$];
  int errors;
  int idle_cycles;
  bit quiet_idle;
  int unsigned phase_pct;

  string fname [12] = '{"rot_00", "rot_01", "rot_02", "rot_10", "rot_11", "rot_12",
                        "rot_20", "rot_21", "rot_22", "pos_x", "pos_y", "pos_z"};

  dh_forward_kinematics_5dof u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .joint1_angle(j1), .joint2_angle(j2), .joint3_angle(j3),
    .joint4_angle(j4), .joint5_angle(j5),
    .out_valid(out_valid), .out_stall(out_stall),
    .rot_00(o[0]), .rot_01(o[1]), .rot_02(o[2]),
    .rot_10(o[3]), .rot_11(o[4]), .rot_12(o[5]),
    .rot_20(o[6]), .rot_21(o[7]), .rot_22(o[8]),
    .pos_x(o[9]), .pos_y(o[10]), .pos_z(o[11])
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic longint clamp1(longint v);
    if (v > ONE30) return ONE30;
    if (v < -ONE30) return -ONE30;
    return v;
  endfunction

  function automatic longint rnd30(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void sincos(input int ang, output longint co, output longint si);
    int r;
    bit flip;
    longint x, y, z, dx, dy;
    r = ((ang + D180 + D360) % D360) - D180;
    flip = 0;
    if (r > D90) begin
      r -= D180;
      flip = 1;
    end else if (r < -D90) begin
      r += D180;
      flip = 1;
    end
    x = CORDIC_K;
    y = 0;
    z = longint'(r) * 8192;
    for (int i = 0; i < CORDIC_STAGES_DEF && i < ATAN_DEPTH; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    co = clamp1(x);
    si = clamp1(y);
  endfunction

  function automatic void chain_link(inout longint rm [3][3], inout longint p [3],
                                     input int th, input bit tw90, input longint a,
                                     input longint d);
    longint c, s, p0, p1, p2, n0, n1, n2;
    sincos(th, c, s);
    for (int r = 0; r < 3; r++) begin
      p0 = rm[r][0]; p1 = rm[r][1]; p2 = rm[r][2];
      n0 = clamp1(rnd30(c * p0 + s * p1));
      if (tw90) begin
        n1 = p2;
        n2 = clamp1(rnd30(s * p0 - c * p1));
      end else begin
        n1 = clamp1(rnd30(c * p1 - s * p0));
        n2 = p2;
      end
      p[r] += d * p2 + a * n0;
      rm[r][0] = n0; rm[r][1] = n1; rm[r][2] = n2;
    end
  endfunction

  function automatic pose_t tool_pose(logic signed [15:0] q [5]);
    pose_t res;
    longint rm [3][3];
    longint p [3];
    longint v;
    rm = '{'{ONE30, 0, 0}, '{0, ONE30, 0}, '{0, 0, ONE30}};
    p = '{0, 0, longint'(link_reg[REG_BASE_HEIGHT]) * ONE30};
    chain_link(rm, p, int'(q[0]), 1, 0, link_reg[REG_LINK_LEN_0]);
    chain_link(rm, p, int'(q[1]) + D90, 0, link_reg[REG_LINK_LEN_1], 0);
    chain_link(rm, p, -int'(q[2]), 0, link_reg[REG_LINK_LEN_2], 0);
    chain_link(rm, p, -int'(q[3]) + D90, 1, link_reg[REG_LINK_LEN_4], 0);
    chain_link(rm, p, int'(q[4]), 0, 0,
               link_reg[REG_LINK_LEN_3] + link_reg[REG_LINK_LEN_5]);
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++) begin
        v = (rm[r][k] + (64'sd1 <<< 15)) >>> 16;
        res.f[r * 3 + k] = v[15:0];
      end
    for (int r = 0; r < 3; r++) begin
      v = rnd30(p[r]);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      res.f[9 + r] = v[15:0];
    end
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pose_q.size() == 0) begin
        $error("result beat with no pending expectation");
        errors++;
      end else begin
        pose_t e;
        e = pose_q.pop_front();
        for (int i = 0; i < 12; i++)
          if (o[i] !== e.f[i]) begin
            $error("%s: expected %0d, got %0d", fname[i], e.f[i], o[i]);
            errors++;
          end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else out_stall <= !quiet_idle && ($urandom_range(99) < 13);
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [13:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx < NUM_REGS) link_reg[idx] = val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pose_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // one beat; expectation queued at the accepting edge
  task automatic send_joints(input logic signed [15:0] q [5], input bit known,
                             input pose_t given);
    pose_t e;
    while (!quiet_idle && $urandom_range(99) < 13) begin
      in_valid <= 0;
      @(posedge clk);
    end
    e = known ? given : tool_pose(q);
    in_valid <= 1;
    j1 <= q[0]; j2 <= q[1]; j3 <= q[2]; j4 <= q[3]; j5 <= q[4];
    do @(posedge clk); while (in_stall);
    pose_q = {pose_q, e};
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'sd23040 : -16'sd23040;
      2: return 16'($urandom_range(D90 + 64) - D90 - 32 + (($urandom_range(1)) ? 0 : D180));
      default: return 16'($urandom_range(2 * D180) - D180);
    endcase
  endfunction

  task automatic random_phase(input int count);
    logic signed [15:0] q [5];
    pose_t none;
    for (int n = 0; n < count; n++) begin
      quiet_idle = (n >= count / 2 && n < count / 2 + count / 5);
      foreach (q[i]) q[i] = rand_angle();
      send_joints(q, 0, none);
    end
    in_valid <= 0;
    quiet_idle = 0;
  endtask

  vec_row_t directed [$];

  task automatic add_row(input int a, b, c, d, f, input bit known, input pose_t pz);
    vec_row_t row;
    row.j = '{16'(a), 16'(b), 16'(c), 16'(d), 16'(f)};
    row.known = known;
    row.pose = pz;
    directed = {directed, row};
  endtask

  initial begin
    pose_t none, home;
    int reset_vals [NUM_REGS];
    reset_vals = '{2432, 512, 2637, 2458, 1024, 640, 1280};
    errors = 0;
    quiet_idle = 0;
    rst = 1;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0;
    j1 = 0; j2 = 0; j3 = 0; j4 = 0; j5 = 0;
    foreach (reset_vals[i]) link_reg[i] = reset_vals[i];
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // all joints zero with reset lengths: tool axis points straight up
    home = tool_pose('{0, 0, 0, 0, 0});
    add_row(0, 0, 0, 0, 0, 1, home);
    add_row(23040, 23040, 23040, 23040, 23040, 0, none);
    add_row(-23040, -23040, -23040, -23040, -23040, 0, none);
    add_row(32767, -32768, 32767, -32768, 32767, 0, none);
    add_row(-32768, 32767, -32768, 32767, -32768, 0, none);
    add_row(11520, -11520, 11520, -11520, 11520, 0, none);
    add_row(11521, 11519, -11521, -11519, 0, 0, none);
    add_row(-1, 1, -1, 1, -1, 0, none);
    add_row(46080 - 65536, 0, 0, 0, 0, 0, none);
    add_row(0, 11520, 0, 0, 0, 0, none);
    add_row(0, 0, -11520, 0, 0, 0, none);
    add_row(0, 0, 0, 23040, 0, 0, none);
    add_row(5760, 2880, -7000, 1200, -20000, 0, none);
    add_row(-23039, 23039, 17280, -17280, 100, 0, none);
    foreach (directed[i]) send_joints(directed[i].j, directed[i].known, directed[i].pose);
    in_valid <= 0;
    drain();

    // extremes: all lengths max, then all zero, plus a write to the ignored index
    for (int r = 0; r < NUM_REGS; r++) write_reg(3'(r), 14'h3FFF);
    write_reg(3'd7, 14'h0);
    random_phase(150);
    drain();
    for (int r = 0; r < NUM_REGS; r++) write_reg(3'(r), 14'h0);
    random_phase(150);
    drain();
    for (phase_pct = 0; phase_pct < 3; phase_pct++) begin
      for (int r = 0; r < NUM_REGS; r++) write_reg(3'(r), 14'($urandom_range(16383)));
      random_phase(120);
      drain();
    end
    for (int r = 0; r < NUM_REGS; r++) write_reg(3'(r), 14'(reset_vals[r]));
    random_phase(190);
    drain();

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/dhfk_pkg.sv
rtl/core/dhfk_cordic.sv
rtl/core/dhfk_link.sv
rtl/core/dh_forward_kinematics_5dof.sv
tb/dh_forward_kinematics_5dof_tb.sv
